// File: rtl/core/acu_pkg.sv
// Shared types and constants for the ADMM constraint update unit.
`default_nettype none
package acu_pkg;

  localparam int unsigned REG_W = 63;
  localparam int unsigned RELAX_W = 34;
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned DIV_STEPS = 65;

  localparam logic [1:0] KIND_INEQ = 2'd0;
  localparam logic [1:0] KIND_EQ = 2'd1;
  localparam logic [1:0] KIND_INF = 2'd2;

  localparam logic [2:0] REG_BASE_PENALTY = 3'd0;
  localparam logic [2:0] REG_EQ_SCALE = 3'd1;
  localparam logic [2:0] REG_INF_PENALTY = 3'd2;
  localparam logic [2:0] REG_INF_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_EQ_TOLERANCE = 3'd4;
  localparam logic [2:0] REG_RELAXATION = 3'd5;

  localparam logic [REG_W-1:0] RST_BASE_PENALTY = 63'd429496730;
  localparam logic [REG_W-1:0] RST_EQ_SCALE = 63'd4294967296000;
  localparam logic [REG_W-1:0] RST_INF_PENALTY = 63'd4295;
  localparam logic [REG_W-1:0] RST_INF_THRESHOLD = 63'd4294967296000000000;
  localparam logic [REG_W-1:0] RST_EQ_TOLERANCE = 63'd4295;
  localparam logic [RELAX_W-1:0] RST_RELAXATION = 34'd6871947674;

  localparam logic [REG_W-1:0] MAX_POS = {REG_W{1'b1}};
  localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;

  typedef enum logic [1:0] {
    CS_MUL,
    CS_SAT,
    CS_DIV,
    CS_DONE
  } coef_state_t;

  typedef struct packed {
    logic             busy;
    logic [REG_W-1:0] rho_ineq;
    logic [REG_W-1:0] rho_eq;
    logic [REG_W-1:0] rho_inf;
    logic [REG_W-1:0] inv_ineq;
    logic [REG_W-1:0] inv_eq;
    logic [REG_W-1:0] inv_inf;
  } coef_t;

  typedef struct packed {
    logic signed [63:0] lower_bound;
    logic signed [63:0] upper_bound;
    logic signed [63:0] previous_slack;
    logic signed [63:0] dual_value;
    logic signed [63:0] solve_output;
  } in_t;

  typedef struct packed {
    logic signed [63:0] new_slack;
    logic signed [63:0] new_dual;
    logic signed [63:0] dual_change;
    logic [1:0]         constraint_kind;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/core/acu_qmul.sv
// Three-stage signed Q32.32 multiply, floor, wrapped to 64 bits.
`default_nettype none
module acu_qmul (
  input  wire logic        clk,
  input  wire logic [2:0]  en,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic [63:0]      p
);

  logic [63:0] ll, lh, hl, hh, corr;
  logic [96:0] s;
  logic [63:0] hhc;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ll <= a[31:0] * b[31:0];
      lh <= a[31:0] * b[63:32];
      hl <= a[63:32] * b[31:0];
      hh <= a[63:32] * b[63:32];
      corr <= (a[63] ? b : 64'd0) + (b[63] ? a : 64'd0);
    end
    if (en[1]) begin
      s <= {33'd0, ll} + {1'b0, lh, 32'd0} + {1'b0, hl, 32'd0};
      hhc <= hh - corr;
    end
    if (en[2]) begin
      p <= s[95:32] + {hhc[31:0], 32'd0};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/acu_coef.sv
// Penalty and reciprocal sequencer: equality penalty product and three divisions.
`default_nettype none
module acu_coef (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      restart,
  input  wire logic [acu_pkg::REG_W-1:0] base,
  input  wire logic [acu_pkg::REG_W-1:0] scale,
  input  wire logic [acu_pkg::REG_W-1:0] infp,
  output acu_pkg::coef_t                 coef
);

  acu_pkg::coef_state_t state, state_next;
  logic [1:0]   mcnt;
  logic [1:0]   dsel;
  logic [6:0]   dcnt;
  logic [125:0] acc;
  logic [62:0]  rem;
  logic [64:0]  q;
  logic [62:0]  rho_eq, inv_ineq, inv_eq, inv_inf;
  logic [31:0]  ap, bp;
  logic [63:0]  pp;
  logic [125:0] pp_sh;
  logic [62:0]  dsor;
  logic [63:0]  trial;
  logic         ge;
  logic [62:0]  rem_next;
  logic [64:0]  q_next;
  logic [62:0]  inv_res;
  logic [63:0]  sh;
  logic         last;

  always_comb begin
    ap = mcnt[1] ? {1'b0, base[62:32]} : base[31:0];
    bp = mcnt[0] ? {1'b0, scale[62:32]} : scale[31:0];
    pp = ap * bp;
    case (mcnt)
      2'd0: pp_sh = {62'd0, pp};
      2'd3: pp_sh = {pp, 62'd0} >> 62'd62 << 64;
      default: pp_sh = {30'd0, pp, 32'd0};
    endcase
    sh = acc[95:32];
    case (dsel)
      acu_pkg::KIND_INEQ: dsor = base;
      acu_pkg::KIND_EQ: dsor = rho_eq;
      default: dsor = infp;
    endcase
    trial = {rem, (dcnt == 7'd0)};
    ge = trial >= {1'b0, dsor};
    rem_next = ge ? 63'(trial - {1'b0, dsor}) : trial[62:0];
    q_next = {q[63:0], ge};
    inv_res = (q_next[64:63] != 2'd0) ? acu_pkg::MAX_POS : q_next[62:0];
    last = dcnt == 7'(acu_pkg::DIV_STEPS - 1);
  end

  always_comb begin
    state_next = state;
    case (state)
      acu_pkg::CS_MUL: if (mcnt == 2'd3) state_next = acu_pkg::CS_SAT;
      acu_pkg::CS_SAT: state_next = acu_pkg::CS_DIV;
      acu_pkg::CS_DIV: if (last && dsel == acu_pkg::KIND_INF) state_next = acu_pkg::CS_DONE;
      acu_pkg::CS_DONE: state_next = acu_pkg::CS_DONE;
      default: state_next = acu_pkg::CS_MUL;
    endcase
  end

  always_comb begin
    coef.busy = state != acu_pkg::CS_DONE;
    coef.rho_ineq = base;
    coef.rho_eq = rho_eq;
    coef.rho_inf = infp;
    coef.inv_ineq = inv_ineq;
    coef.inv_eq = inv_eq;
    coef.inv_inf = inv_inf;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= acu_pkg::CS_MUL;
      mcnt <= 2'd0;
      dsel <= acu_pkg::KIND_INEQ;
      dcnt <= 7'd0;
      acc <= '0;
      rem <= '0;
      q <= '0;
    end else begin
      state <= state_next;
      case (state)
        acu_pkg::CS_MUL: begin
          acc <= acc + pp_sh;
          mcnt <= mcnt + 2'd1;
        end
        acu_pkg::CS_SAT: begin
          rho_eq <= (acc[125:96] != 30'd0 || sh[63]) ? acu_pkg::MAX_POS : sh[62:0];
        end
        acu_pkg::CS_DIV: begin
          if (last) begin
            case (dsel)
              acu_pkg::KIND_INEQ: inv_ineq <= inv_res;
              acu_pkg::KIND_EQ: inv_eq <= inv_res;
              default: inv_inf <= inv_res;
            endcase
            dsel <= dsel + 2'd1;
            dcnt <= 7'd0;
            rem <= '0;
            q <= '0;
          end else begin
            dcnt <= dcnt + 7'd1;
            rem <= rem_next;
            q <= q_next;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/admm_constraint_update_unit.sv
// One beat per cycle sustained while out_stall is low and the coefficients are not busy.
// Each stage holds when its successor is full and stalled; bubbles close up.
// The reciprocals of the three penalties come from a shared sequencer, which runs 4 partial
// products, 1 saturate and 3 x 65 division steps after reset and after every register write,
// during which input is stalled. Registers reset to defaults.
`default_nettype none
module admm_constraint_update_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire acu_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output acu_pkg::out_t                    out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [acu_pkg::PADDR_W-1:0] paddr,
  input  wire logic [63:0]                 pwdata,
  output logic [63:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned NS = 17;

  logic [62:0] base_penalty, equality_penalty_scale, infinite_penalty;
  logic [62:0] infinity_threshold, equality_tolerance;
  logic [33:0] relaxation;
  logic        cfg_we;
  logic [2:0]  ridx;
  acu_pkg::coef_t coef;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign ridx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_penalty <= acu_pkg::RST_BASE_PENALTY;
      equality_penalty_scale <= acu_pkg::RST_EQ_SCALE;
      infinite_penalty <= acu_pkg::RST_INF_PENALTY;
      infinity_threshold <= acu_pkg::RST_INF_THRESHOLD;
      equality_tolerance <= acu_pkg::RST_EQ_TOLERANCE;
      relaxation <= acu_pkg::RST_RELAXATION;
    end else if (cfg_we) begin
      case (ridx)
        acu_pkg::REG_BASE_PENALTY: base_penalty <= pwdata[62:0];
        acu_pkg::REG_EQ_SCALE: equality_penalty_scale <= pwdata[62:0];
        acu_pkg::REG_INF_PENALTY: infinite_penalty <= pwdata[62:0];
        acu_pkg::REG_INF_THRESHOLD: infinity_threshold <= pwdata[62:0];
        acu_pkg::REG_EQ_TOLERANCE: equality_tolerance <= pwdata[62:0];
        acu_pkg::REG_RELAXATION: relaxation <= pwdata[33:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      acu_pkg::REG_BASE_PENALTY: prdata = {1'b0, base_penalty};
      acu_pkg::REG_EQ_SCALE: prdata = {1'b0, equality_penalty_scale};
      acu_pkg::REG_INF_PENALTY: prdata = {1'b0, infinite_penalty};
      acu_pkg::REG_INF_THRESHOLD: prdata = {1'b0, infinity_threshold};
      acu_pkg::REG_EQ_TOLERANCE: prdata = {1'b0, equality_tolerance};
      acu_pkg::REG_RELAXATION: prdata = {30'd0, relaxation};
      default: prdata = 64'd0;
    endcase
  end

  acu_coef u_coef (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .base    (base_penalty),
    .scale   (equality_penalty_scale),
    .infp    (infinite_penalty),
    .coef    (coef)
  );

  // stage control
  logic [NS-1:0] v;
  logic [NS-1:0] ld;

  always_comb begin
    ld[NS-1] = !v[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign in_stall = coef.busy || !ld[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid && !coef.busy;
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: capture and classify
  logic [63:0] thr, neg_thr, gap, sol0;
  logic        is_inf, is_inv, gap_lt;
  logic [63:0] lo_s [0:10];
  logic [63:0] up_s [0:11];
  logic [63:0] y_s [0:15];
  logic [1:0]  kind_s [0:15];
  logic [63:0] zp_s [0:4];
  logic [62:0] rho_s [1:12];
  logic [63:0] pz_s [5:8];
  logic [63:0] py_s [5:9];
  logic [63:0] relax_s [9:11];
  logic [63:0] zc_s [11:15];
  logic [63:0] d1, inv1, zt5, z10, diff12;
  logic [63:0] pa, py, pz, pb, pc;
  logic [63:0] zclo;
  logic [63:0] alpha, oma;

  always_comb begin
    thr = {1'b0, infinity_threshold};
    neg_thr = 64'd0 - thr;
    is_inf = ($signed(in_data.lower_bound) < $signed(neg_thr))
          || ($signed(thr) < $signed(in_data.upper_bound));
    is_inv = $signed(in_data.upper_bound) < $signed(in_data.lower_bound);
    gap = in_data.upper_bound - in_data.lower_bound;
    gap_lt = gap < {1'b0, equality_tolerance};
    alpha = {30'd0, relaxation};
    oma = acu_pkg::ONE_Q - alpha;
    zclo = ($signed(z10) < $signed(lo_s[10])) ? lo_s[10] : z10;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      lo_s[0] <= in_data.lower_bound;
      up_s[0] <= in_data.upper_bound;
      zp_s[0] <= in_data.previous_slack;
      y_s[0] <= in_data.dual_value;
      sol0 <= in_data.solve_output;
      kind_s[0] <= is_inf ? acu_pkg::KIND_INF
                 : (is_inv || gap_lt) ? acu_pkg::KIND_EQ : acu_pkg::KIND_INEQ;
    end
    for (int k = 1; k <= 10; k++) if (ld[k]) lo_s[k] <= lo_s[k-1];
    for (int k = 1; k <= 11; k++) if (ld[k]) up_s[k] <= up_s[k-1];
    for (int k = 1; k <= 15; k++) if (ld[k]) begin
      y_s[k] <= y_s[k-1];
      kind_s[k] <= kind_s[k-1];
    end
    for (int k = 1; k <= 4; k++) if (ld[k]) zp_s[k] <= zp_s[k-1];
    if (ld[1]) begin
      d1 <= sol0 - y_s[0];
      case (kind_s[0])
        acu_pkg::KIND_INF: begin
          rho_s[1] <= coef.rho_inf;
          inv1 <= {1'b0, coef.inv_inf};
        end
        acu_pkg::KIND_EQ: begin
          rho_s[1] <= coef.rho_eq;
          inv1 <= {1'b0, coef.inv_eq};
        end
        default: begin
          rho_s[1] <= coef.rho_ineq;
          inv1 <= {1'b0, coef.inv_ineq};
        end
      endcase
    end
    for (int k = 2; k <= 12; k++) if (ld[k]) rho_s[k] <= rho_s[k-1];
    if (ld[5]) begin
      zt5 <= zp_s[4] + pa;
      pz_s[5] <= pz;
      py_s[5] <= py;
    end
    for (int k = 6; k <= 8; k++) if (ld[k]) pz_s[k] <= pz_s[k-1];
    for (int k = 6; k <= 9; k++) if (ld[k]) py_s[k] <= py_s[k-1];
    if (ld[9]) relax_s[9] <= pb + pz_s[8];
    if (ld[10]) begin
      relax_s[10] <= relax_s[9];
      z10 <= relax_s[9] + py_s[9];
    end
    if (ld[11]) begin
      relax_s[11] <= relax_s[10];
      zc_s[11] <= ($signed(up_s[10]) < $signed(zclo)) ? up_s[10] : zclo;
    end
    if (ld[12]) diff12 <= relax_s[11] - zc_s[11];
    for (int k = 12; k <= 15; k++) if (ld[k]) zc_s[k] <= zc_s[k-1];
    if (ld[16]) begin
      out_data.new_slack <= zc_s[15];
      out_data.new_dual <= y_s[15] + pc;
      out_data.dual_change <= pc;
      out_data.constraint_kind <= kind_s[15];
    end
  end

  acu_qmul u_mul_a (.clk(clk), .en(ld[4:2]), .a(inv1), .b(d1), .p(pa));
  acu_qmul u_mul_y (.clk(clk), .en(ld[4:2]), .a(inv1), .b(y_s[1]), .p(py));
  acu_qmul u_mul_z (.clk(clk), .en(ld[4:2]), .a(oma), .b(zp_s[1]), .p(pz));
  acu_qmul u_mul_b (.clk(clk), .en(ld[8:6]), .a(alpha), .b(zt5), .p(pb));
  acu_qmul u_mul_c (.clk(clk), .en(ld[15:13]), .a({1'b0, rho_s[12]}), .b(diff12), .p(pc));

  a_restart_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> coef.busy) else $error("register write did not restart coefficient sequencer");

  a_no_entry_busy: assert property (@(posedge clk) disable iff (rst)
    (coef.busy && ld[0]) |=> !v[0]) else $error("item entered while coefficients busy");

  a_clamp_upper: assert property (@(posedge clk) disable iff (rst)
    v[11] |-> ($signed(zc_s[11]) <= $signed(up_s[11]))) else $error("slack above upper bound");

endmodule
`default_nettype wire
